FILE: rtl/core/ucfp_pkg.sv
// ---------------------------------------------------------------------------
// ucfp_pkg: shared types and constants of the UART command frame parser
// Holds the frame layout, character codes, the configuration record, the
// request record handed from the frame tracker to the response generator,
// and the fixed error text.
// ---------------------------------------------------------------------------
`default_nettype none

package ucfp_pkg;

    // Character codes
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    // Frame layout
    localparam int FRAME_LEN = 15;
    localparam int HEAD_LEN  = 10;   // positions 0..9 are echoed unchanged
    localparam int ECHO_LEN  = FRAME_LEN + 1;
    localparam int ERR_LEN   = 37;

    localparam logic [4:0] POS_TYPE      = 5'd8;
    localparam logic [4:0] POS_KIND      = 5'd9;
    localparam logic [4:0] POS_DIGIT0    = 5'd10;
    localparam logic [4:0] POS_DIGIT3    = 5'd13;
    localparam logic [4:0] POS_END       = 5'd14;
    localparam logic [4:0] POS_FULL      = 5'd15;
    localparam logic [4:0] POS_SATURATED = 5'd16;

    // Configuration register indexes
    localparam logic [7:0] REG_HEADER    = 8'd0;
    localparam logic [7:0] REG_TYPE      = 8'd1;
    localparam logic [7:0] REG_DATA_KIND = 8'd2;
    localparam logic [7:0] REG_END       = 8'd3;

    // Fixed error response, first character in the top bits
    localparam logic [ERR_LEN*8-1:0] ERR_TEXT =
        {"Eksik veya Hatali Tuslama Yaptiniz!!", LF_CHAR};

    typedef struct packed {
        logic [63:0] header;
        logic [7:0]  frame_type;
        logic [7:0]  data_kind;
        logic [7:0]  end_byte;
    } cfg_t;

    typedef enum logic [1:0] {
        RESP_PERIOD = 2'd0,
        RESP_ECHO   = 2'd1,
        RESP_ERROR  = 2'd2
    } resp_kind_t;

    // Response request issued when a carriage return closes a frame
    typedef struct packed {
        logic                       valid;
        resp_kind_t                 kind;
        logic [15:0]                period;
        logic [15:0]                count;
        logic [HEAD_LEN-1:0][7:0]   head;
        logic [7:0]                 end_byte;
    } frame_req_t;

    // Character of the error text at a given index
    function automatic logic [7:0] err_char(input logic [5:0] idx);
        logic [5:0] rev;
        begin
            rev = 6'(ERR_LEN - 1) - idx;
            return ERR_TEXT[{rev, 3'b000} +: 8];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ucfp_frame.sv
// ---------------------------------------------------------------------------
// ucfp_frame: frame position tracker and field checker
// Consumes one received character per step, checks fixed positions against
// the configured bytes, keeps the echoed bytes, builds the period value and
// issues a response request when a carriage return closes the frame.
// ---------------------------------------------------------------------------
`default_nettype none

module ucfp_frame
    import ucfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] timer_count,
    output frame_req_t       req
);

    logic [4:0]               pos_reg,      pos_next;
    logic                     mismatch_reg, mismatch_next;
    logic                     set_mode_reg, set_mode_next;
    logic [15:0]              acc_reg,      acc_next;
    logic [HEAD_LEN-1:0][7:0] head_reg,     head_next;
    logic [7:0]               end_reg,      end_next;

    logic        is_cr;
    logic [7:0]  hdr_byte;
    logic [15:0] digit;
    logic [15:0] acc_times_ten;

    assign is_cr    = (rx_byte == CR_CHAR);
    assign hdr_byte = cfg.header[{pos_reg[2:0], 3'b000} +: 8];
    assign digit    = {8'd0, rx_byte - DIGIT_BASE};
    assign acc_times_ten = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0};

    // Next frame state for one character
    always_comb
    begin
        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        set_mode_next = set_mode_reg;
        acc_next      = acc_reg;
        head_next     = head_reg;
        end_next      = end_reg;
        if (step)
        begin
            if (is_cr)
            begin
                pos_next      = 5'd0;
                mismatch_next = 1'b0;
            end
            else
            begin
                if (pos_reg < POS_TYPE)
                begin
                    if (rx_byte != hdr_byte)
                    begin
                        mismatch_next = 1'b1;
                    end
                end
                else if (pos_reg == POS_TYPE)
                begin
                    set_mode_next = (rx_byte == cfg.frame_type);
                end
                else if (pos_reg == POS_KIND)
                begin
                    if (rx_byte != cfg.data_kind)
                    begin
                        mismatch_next = 1'b1;
                    end
                end
                else if (pos_reg == POS_END)
                begin
                    if (rx_byte != cfg.end_byte)
                    begin
                        mismatch_next = 1'b1;
                    end
                end

                // Keep the bytes that are echoed unchanged
                if (pos_reg < 5'(HEAD_LEN))
                begin
                    head_next[pos_reg[3:0]] = rx_byte;
                end
                if (pos_reg == POS_END)
                begin
                    end_next = rx_byte;
                end

                // Period built digit by digit in Horner form
                if (pos_reg == POS_DIGIT0)
                begin
                    acc_next = digit;
                end
                else if (pos_reg > POS_DIGIT0 && pos_reg <= POS_DIGIT3)
                begin
                    acc_next = acc_times_ten + digit;
                end

                if (pos_reg < POS_SATURATED)
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 5'd0;
            mismatch_reg <= 1'b0;
            set_mode_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
            set_mode_reg <= set_mode_next;
        end
    end

    // Frame payload
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        head_reg <= head_next;
        end_reg  <= end_next;
    end

    // Response request on frame close
    always_comb
    begin
        req.valid    = step && is_cr;
        req.period   = acc_reg;
        req.count    = timer_count;
        req.head     = head_reg;
        req.end_byte = end_reg;
        if (pos_reg == POS_FULL && !mismatch_reg)
        begin
            req.kind = set_mode_reg ? RESP_PERIOD : RESP_ECHO;
        end
        else
        begin
            req.kind = RESP_ERROR;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ucfp_resp.sv
// ---------------------------------------------------------------------------
// ucfp_resp: response generator
// Holds one response and sends it one transfer per cycle while out_ready
// is high: a period load, the 16-character echo or the 37-character error
// text. The timer count is turned into four decimal digits, one per cycle,
// while the leading echo characters go out.
// ---------------------------------------------------------------------------
`default_nettype none

module ucfp_resp
    import ucfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire frame_req_t  req,
    output logic             idle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       tx_byte,
    output logic             tx_valid,
    output logic             period_write,
    output logic [15:0]      new_period,
    output logic             last
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PERIOD = 4'b0010,
        ST_ECHO   = 4'b0100,
        ST_ERROR  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  idx_reg,   idx_next;
    logic [2:0]  conv_cnt_reg;
    logic [15:0] conv_val_reg;
    logic [15:0] period_reg;
    logic [ECHO_LEN-1:0][7:0] echo_reg;

    logic        advance;
    logic [31:0] conv_prod;
    logic [12:0] conv_quot;
    logic [15:0] conv_rem;
    logic [3:0]  conv_idx;

    // Divide by ten through the reciprocal, exact for all 16-bit values
    assign conv_prod = conv_val_reg * 16'd52429;
    assign conv_quot = conv_prod[31:19];
    assign conv_rem  = conv_val_reg - ({conv_quot, 3'b000} + {2'b00, conv_quot, 1'b0});
    assign conv_idx  = 4'd9 + {1'b0, conv_cnt_reg};

    assign idle      = (state_reg == ST_IDLE);
    assign out_valid = !idle;
    assign advance   = out_valid && out_ready;

    // Output characters
    always_comb
    begin
        tx_byte      = 8'd0;
        tx_valid     = 1'b0;
        period_write = 1'b0;
        new_period   = 16'd0;
        last         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_PERIOD:
            begin
                period_write = 1'b1;
                new_period   = period_reg;
                last         = 1'b1;
            end
            ST_ECHO:
            begin
                tx_byte  = echo_reg[idx_reg[3:0]];
                tx_valid = 1'b1;
                last     = (idx_reg == 6'(ECHO_LEN - 1));
            end
            ST_ERROR:
            begin
                tx_byte  = err_char(idx_reg);
                tx_valid = 1'b1;
                last     = (idx_reg == 6'(ERR_LEN - 1));
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (idle)
        begin
            if (req.valid)
            begin
                idx_next = 6'd0;
                case (req.kind)
                    RESP_PERIOD: state_next = ST_PERIOD;
                    RESP_ECHO:   state_next = ST_ECHO;
                    default:     state_next = ST_ERROR;
                endcase
            end
        end
        else if (advance)
        begin
            if (last)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                idx_next = idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 6'd0;
            conv_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (idle && req.valid)
            begin
                conv_cnt_reg <= 3'd4;
            end
            else if (conv_cnt_reg != 3'd0)
            begin
                conv_cnt_reg <= conv_cnt_reg - 3'd1;
            end
        end
    end

    // Response payload and digit conversion
    always_ff @(posedge clk)
    begin
        if (idle && req.valid)
        begin
            period_reg   <= req.period;
            conv_val_reg <= req.count;
            for (int i = 0; i < HEAD_LEN; i++)
            begin
                echo_reg[i] <= req.head[i];
            end
            echo_reg[FRAME_LEN - 1] <= req.end_byte;
            echo_reg[FRAME_LEN]     <= LF_CHAR;
        end
        else if (conv_cnt_reg != 3'd0)
        begin
            conv_val_reg       <= {3'b000, conv_quot};
            echo_reg[conv_idx] <= DIGIT_BASE + {4'd0, conv_rem[3:0]};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/uart_command_frame_parser.sv
// ---------------------------------------------------------------------------
// uart_command_frame_parser: command frame parser for a serial console
// Registers received characters, tracks the command frame and streams the
// period load, echo or error response.
// ---------------------------------------------------------------------------
// Characters enter through the slave stream at up to one per cycle; an
// ordinary character is absorbed by the input register and then by the frame
// tracker, also while a response is still being sent. A carriage return
// is taken from the input register only when the response generator is
// idle, so a frame end waits for the previous response to drain. A response
// takes 1 transfer (period load), 16 transfers (echo) or 37 transfers
// (error text), one per cycle while m_tready is high. The configuration
// port always accepts and must only be written while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_command_frame_parser
    import ucfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [63:0] cfg_data,

    // Received characters
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte[7:0], timer_count[23:8]

    // Responses
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // tx_byte[7:0], new_period[23:8]
    output logic [1:0]       m_tuser,   // tx_valid[0], period_write[1]
    output logic             m_tlast
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_count_reg;

    logic        gen_idle;
    logic        consume;
    frame_req_t  req;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        period_write;
    logic [15:0] new_period;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEADER:    cfg_reg.header     <= cfg_data;
                REG_TYPE:      cfg_reg.frame_type <= cfg_data[7:0];
                REG_DATA_KIND: cfg_reg.data_kind  <= cfg_data[7:0];
                REG_END:       cfg_reg.end_byte   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register; a frame end holds until the response side is free
    assign consume  = in_valid_reg && (in_byte_reg != CR_CHAR || gen_idle);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata[7:0];
            in_count_reg <= s_tdata[23:8];
        end
    end

    ucfp_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .step        (consume),
        .rx_byte     (in_byte_reg),
        .timer_count (in_count_reg),
        .req         (req)
    );

    ucfp_resp u_resp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .idle         (gen_idle),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .tx_byte      (tx_byte),
        .tx_valid     (tx_valid),
        .period_write (period_write),
        .new_period   (new_period),
        .last         (m_tlast)
    );

    // Output packing
    assign m_tdata = {new_period, tx_byte};
    assign m_tuser = {period_write, tx_valid};

endmodule

`default_nettype wire
